/* rtl/ifscg_pkg.sv */
// Shared types and constants of the chaos-game plotter.
package ifscg_pkg;

    localparam int WORDS_PER_MAP = 7;
    localparam logic [2:0] WEIGHT_WORD = 3'd6;
    localparam logic [12:0] SIZE_LIMIT = 13'd4096;

    localparam logic [12:0] WIDTH_RESET  = 13'd640;
    localparam logic [12:0] HEIGHT_RESET = 13'd480;
    localparam logic [31:0] SCALE_RESET  = 32'd6553600;
    localparam logic [3:0]  COUNT_RESET  = 4'd1;

    // One classified request on its way from the front to the back.
    typedef struct packed {
        logic        step;
        logic        load_en;
        logic [2:0]  map_index;
        logic [2:0]  word_select;
        logic [31:0] word_value;
        logic [15:0] random_draw;
    } req_t;

    // Configuration registers as seen by the back.
    typedef struct packed {
        logic [12:0] image_width;
        logic [12:0] image_height;
        logic [31:0] pixel_scale;
        logic [3:0]  map_count;
    } cfg_t;

endpackage

/* rtl/ifscg_front.sv */
// Front of the plotter: accepts requests, classifies them and queues them.
module ifscg_front #(
    parameter int MAX_MAPS = 8
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [55:0]      s_tdata,
    input  logic             s_tuser,
    output logic             q_valid,
    output ifscg_pkg::req_t  q_req,
    input  logic             q_pop
);

    ifscg_pkg::req_t entry_reg [2];
    logic            wr_ptr_reg;
    logic            rd_ptr_reg;
    logic [1:0]      cnt_reg;
    ifscg_pkg::req_t req_in;
    logic            push;
    logic            pop;

    // A load is only carried out when it names an existing word.
    always_comb begin
        req_in.step        = s_tuser;
        req_in.map_index   = s_tdata[2:0];
        req_in.word_select = s_tdata[5:3];
        req_in.word_value  = s_tdata[37:6];
        req_in.random_draw = s_tdata[53:38];
        req_in.load_en     = !s_tuser && (32'(s_tdata[2:0]) < 32'(MAX_MAPS))
                             && (s_tdata[5:3] <= ifscg_pkg::WEIGHT_WORD);
    end

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_req    = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= req_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 2'd1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 2'd1;
            end
        end
    end

endmodule

/* rtl/ifscg_back.sv */
// Back of the plotter: map table, map selection, affine transform and pixel mapping.
module ifscg_back #(
    parameter int MAX_MAPS    = 8,
    parameter int RANDOM_BITS = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  ifscg_pkg::req_t  q_req,
    output logic             q_pop,
    input  ifscg_pkg::cfg_t  cfg,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [11:0]      pixel_x,
    output logic [11:0]      pixel_y,
    output logic             hit
);

    localparam int DEPTH = MAX_MAPS * ifscg_pkg::WORDS_PER_MAP;
    localparam int AW    = $clog2(DEPTH);
    localparam int MIW   = $clog2(MAX_MAPS);
    localparam int KW    = (MIW + 1 > 3) ? MIW + 1 : 3;
    localparam int TW    = 31 + MIW;
    localparam int NCH   = (RANDOM_BITS + 15) / 16;
    localparam int DW    = NCH * 16;
    localparam int ACCW  = TW + DW;
    localparam int CHW   = $clog2(NCH) + 1;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUM  = 3'd1;
    localparam logic [2:0] ST_THR  = 3'd2;
    localparam logic [2:0] ST_PICK = 3'd3;
    localparam logic [2:0] ST_COEF = 3'd4;
    localparam logic [2:0] ST_MUL  = 3'd5;

    localparam logic signed [65:0] FAR_POS = 66'sd1152921504606846976;
    localparam logic signed [65:0] FAR_NEG = -66'sd1152921504606846976;

    logic [31:0]       mem [DEPTH];
    logic [DEPTH-1:0]  valid_reg;
    logic [31:0]       rd_data_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     raddr;

    logic [2:0]        state_reg;
    logic [KW-1:0]     k_reg;
    logic [TW-1:0]     total_reg;
    logic [TW-1:0]     cum_reg;
    logic [ACCW-1:0]   acc_reg;
    logic [DW-1:0]     draw_reg;
    logic [CHW-1:0]    chunk_reg;
    logic [KW-1:0]     pick_reg;
    logic [31:0]       coef_reg [6];
    logic [2:0]        s_reg;
    logic signed [65:0] p1_reg;
    logic signed [65:0] prod_reg;
    logic signed [65:0] px_reg;
    logic [31:0]       nx_reg;
    logic [31:0]       ny_reg;
    logic [31:0]       point_x_reg;
    logic [31:0]       point_y_reg;
    logic              out_valid_reg;
    logic [11:0]       pixel_x_reg;
    logic [11:0]       pixel_y_reg;
    logic              hit_reg;

    logic [KW-1:0]     nlast;
    logic [31:0]       word;
    logic [TW-1:0]     wt;
    logic [TW-1:0]     cum_next;
    logic [TW-1:0]     thresh;
    logic [KW-1:0]     k_prev;
    logic [DW-1:0]     draw_in;
    logic [TW+15:0]    part;
    logic signed [32:0] ma;
    logic signed [32:0] mb;
    logic [12:0]       res_x;
    logic [12:0]       res_y;
    logic signed [66:0] base_x;
    logic signed [66:0] base_y;
    logic              out_free;
    logic              result_load;

    function automatic logic [AW-1:0] taddr(input logic [KW-1:0] mi, input logic [2:0] ws);
        logic [31:0] a;
        a = {{(32-KW){1'b0}}, mi} * 32'd7 + {29'd0, ws};
        return a[AW-1:0];
    endfunction

    // Sum of two exact products rounded half up to Q8.24, plus offset, saturated.
    function automatic logic [31:0] affine_sum(input logic signed [65:0] pa,
                                              input logic signed [65:0] pb,
                                              input logic [31:0] off);
        logic signed [65:0] sm;
        logic signed [41:0] sh;
        logic signed [42:0] r;
        sm = pa + pb + 66'sd8388608;
        sh = sm[65:24];
        r  = {sh[41], sh} + $signed({{11{off[31]}}, off});
        if (r > 43'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (r < -43'sd2147483648) begin
            return 32'h8000_0000;
        end
        return r[31:0];
    endfunction

    // Truncate toward zero to a pixel; the top bit says the pixel is in range.
    // A value just below zero truncates to pixel zero, which exists only when
    // the image is not empty.
    function automatic logic [12:0] to_pixel(input logic signed [65:0] p,
                                            input logic signed [66:0] base,
                                            input logic sub, input logic [12:0] lim);
        logic signed [66:0] v;
        logic [66:0] mag;
        logic [26:0] q;
        logic ok;
        v   = sub ? base - p : base + p;
        mag = v[66] ? 67'(-v) : 67'(v);
        q   = mag[66:40];
        ok  = (p < FAR_POS) && (p > FAR_NEG)
              && (v[66] ? ((q == 27'd0) && (lim != 13'd0)) : (q < {14'd0, lim}));
        return {ok, v[66] ? 12'd0 : q[11:0]};
    endfunction

    always_comb begin
        if (cfg.map_count == 4'd0) begin
            nlast = '0;
        end else if (32'(cfg.map_count) > 32'(MAX_MAPS)) begin
            nlast = KW'(MAX_MAPS - 1);
        end else begin
            nlast = KW'(cfg.map_count) - KW'(1);
        end
    end

    assign word     = rd_valid_reg ? rd_data_reg : 32'd0;
    assign wt       = word[31] ? '0 : TW'(word[30:0]);
    assign cum_next = cum_reg + wt;
    assign thresh   = acc_reg[RANDOM_BITS +: TW];
    assign k_prev   = k_reg - KW'(1);
    assign part     = {16'd0, total_reg} * {{TW{1'b0}}, draw_reg[DW-1 -: 16]};
    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = (state_reg == ST_IDLE) && q_valid;
    assign result_load = (state_reg == ST_MUL) && (s_reg == 3'd6) && out_free;

    always_comb begin
        draw_in = '0;
        for (int b = 0; b < DW; b++) begin
            if (b < 16 && b < RANDOM_BITS) begin
                draw_in[b] = q_req.random_draw[b[3:0]];
            end
        end
    end

    always_comb begin
        case (state_reg)
            ST_COEF: raddr = taddr(pick_reg, k_reg[2:0]);
            default: raddr = taddr(k_reg, ifscg_pkg::WEIGHT_WORD);
        endcase
    end

    always_comb begin
        case (s_reg)
            3'd0:    begin ma = $signed({coef_reg[0][31], coef_reg[0]});
                           mb = $signed({point_x_reg[31], point_x_reg}); end
            3'd1:    begin ma = $signed({coef_reg[1][31], coef_reg[1]});
                           mb = $signed({point_y_reg[31], point_y_reg}); end
            3'd2:    begin ma = $signed({coef_reg[2][31], coef_reg[2]});
                           mb = $signed({point_x_reg[31], point_x_reg}); end
            3'd3:    begin ma = $signed({coef_reg[3][31], coef_reg[3]});
                           mb = $signed({point_y_reg[31], point_y_reg}); end
            3'd4:    begin ma = $signed({nx_reg[31], nx_reg});
                           mb = $signed({1'b0, cfg.pixel_scale}); end
            default: begin ma = $signed({ny_reg[31], ny_reg});
                           mb = $signed({1'b0, cfg.pixel_scale}); end
        endcase
    end

    assign base_x = $signed({15'd0, cfg.image_width, 39'd0});
    assign base_y = $signed({14'd0, 1'b0, cfg.image_height[12:1], 40'd0});
    assign res_x  = to_pixel(px_reg, base_x, 1'b0, cfg.image_width);
    assign res_y  = to_pixel(prod_reg, base_y, 1'b1, cfg.image_height);

    // Table memory with registered read; valid bits stand in for the zero reset.
    always_ff @(posedge aclk) begin
        rd_data_reg <= mem[raddr];
        if (q_pop && q_req.load_en) begin
            mem[taddr(KW'(q_req.map_index), q_req.word_select)] <= q_req.word_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end else begin
            rd_valid_reg <= valid_reg[raddr];
            if (q_pop && q_req.load_en) begin
                valid_reg[taddr(KW'(q_req.map_index), q_req.word_select)] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MUL && s_reg != 3'd6) begin
            prod_reg <= ma * mb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            k_reg         <= '0;
            s_reg         <= 3'd0;
            point_x_reg   <= 32'd0;
            point_y_reg   <= 32'd0;
            out_valid_reg <= 1'b0;
        end else begin
            if (result_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (q_valid && q_req.step) begin
                        draw_reg  <= draw_in;
                        total_reg <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_SUM;
                    end
                end
                ST_SUM: begin
                    k_reg <= k_reg + KW'(1);
                    if (k_reg != '0) begin
                        total_reg <= total_reg + wt;
                    end
                    if (k_reg == nlast + KW'(1)) begin
                        acc_reg   <= '0;
                        chunk_reg <= CHW'(NCH - 1);
                        state_reg <= ST_THR;
                    end
                end
                ST_THR: begin
                    acc_reg   <= (acc_reg << 16) + ACCW'(part);
                    draw_reg  <= draw_reg << 16;
                    chunk_reg <= chunk_reg - CHW'(1);
                    k_reg     <= '0;
                    cum_reg   <= '0;
                    if (chunk_reg == '0) begin
                        if (total_reg == '0) begin
                            pick_reg  <= '0;
                            state_reg <= ST_COEF;
                        end else begin
                            state_reg <= ST_PICK;
                        end
                    end
                end
                ST_PICK: begin
                    if (k_reg != '0) begin
                        cum_reg <= cum_next;
                    end
                    if (k_reg != '0 && (thresh < cum_next || k_prev == nlast)) begin
                        pick_reg  <= k_prev;
                        k_reg     <= '0;
                        state_reg <= ST_COEF;
                    end else begin
                        k_reg <= k_reg + KW'(1);
                    end
                end
                ST_COEF: begin
                    k_reg <= k_reg + KW'(1);
                    if (k_reg != '0) begin
                        coef_reg[k_prev[2:0]] <= word;
                    end
                    if (k_reg == KW'(6)) begin
                        s_reg     <= 3'd0;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (s_reg != 3'd6) begin
                        s_reg <= s_reg + 3'd1;
                    end
                    case (s_reg)
                        3'd1:    p1_reg <= prod_reg;
                        3'd2:    nx_reg <= affine_sum(p1_reg, prod_reg, coef_reg[4]);
                        3'd3:    p1_reg <= prod_reg;
                        3'd4:    ny_reg <= affine_sum(p1_reg, prod_reg, coef_reg[5]);
                        3'd5:    px_reg <= prod_reg;
                        default: ;
                    endcase
                    if (result_load) begin
                        point_x_reg   <= nx_reg;
                        point_y_reg   <= ny_reg;
                        hit_reg       <= res_x[12] && res_y[12];
                        pixel_x_reg   <= (res_x[12] && res_y[12]) ? res_x[11:0] : 12'd0;
                        pixel_y_reg   <= (res_x[12] && res_y[12]) ? res_y[11:0] : 12'd0;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign pixel_x  = pixel_x_reg;
    assign pixel_y  = pixel_y_reg;
    assign hit      = hit_reg;

endmodule

/* rtl/ifs_chaos_game_plotter_unit.sv */
// Top level of the iterated-function-system chaos-game plotter.
//
// The block keeps a table of up to MAX_MAPS affine maps (coefficients a..f in
// signed Q8.24 and a selection weight each) and a current point, both cleared
// by reset. A request with tuser low loads one table word and gives no result;
// a request with tuser high draws a map with probability proportional to its
// weight, moves the point through it with a saturating transform and returns
// one result: the pixel the new point lands on and a hit flag in tuser. The
// length of a step grows with n, the number of maps in use, and with
// ceil(RANDOM_BITS/16); it is set by the two walks over the weights through
// the single read port of the table memory and by the six passes through the
// one shared 33x33 multiplier. A two-entry request queue in front and an
// output register behind let both sides stall on their own. The table needs
// no clearing pass after reset. Configuration registers must be written
// through the APB port only while the block is idle; the block does not enforce it.
module ifs_chaos_game_plotter_unit #(
    parameter int MAX_MAPS    = 8,
    parameter int RANDOM_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [55:0] s_tdata,   // map_index[2:0], word_select[5:3],
                                   // word_value[37:6], random_draw[53:38]
    input  logic        s_tuser,   // op: 0 load, 1 step
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pixel_x[11:0], pixel_y[23:12]
    output logic        m_tuser,   // hit
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_SCALE  = 2'd2;
    localparam logic [1:0] REG_COUNT  = 2'd3;

    logic [12:0]     image_width_reg;
    logic [12:0]     image_height_reg;
    logic [31:0]     pixel_scale_reg;
    logic [3:0]      map_count_reg;
    logic [12:0]     size_next;
    logic            cfg_write;
    logic            q_valid;
    logic            q_pop;
    ifscg_pkg::req_t q_req;
    ifscg_pkg::cfg_t cfg;
    logic [11:0]     pixel_x;
    logic [11:0]     pixel_y;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Image sizes whose low 13 bits exceed SIZE_LIMIT saturate to it when written; higher pwdata bits are ignored.
    assign size_next = (pwdata[12:0] > ifscg_pkg::SIZE_LIMIT) ? ifscg_pkg::SIZE_LIMIT
                                                              : pwdata[12:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_width_reg  <= ifscg_pkg::WIDTH_RESET;
            image_height_reg <= ifscg_pkg::HEIGHT_RESET;
            pixel_scale_reg  <= ifscg_pkg::SCALE_RESET;
            map_count_reg    <= ifscg_pkg::COUNT_RESET;
        end else if (cfg_write) begin
            case (paddr[3:2])
                REG_WIDTH:  image_width_reg  <= size_next;
                REG_HEIGHT: image_height_reg <= size_next;
                REG_SCALE:  pixel_scale_reg  <= pwdata;
                REG_COUNT:  map_count_reg    <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_WIDTH:  prdata = {19'd0, image_width_reg};
            REG_HEIGHT: prdata = {19'd0, image_height_reg};
            REG_SCALE:  prdata = pixel_scale_reg;
            REG_COUNT:  prdata = {28'd0, map_count_reg};
            default:    prdata = 32'd0;
        endcase
    end

    always_comb begin
        cfg.image_width  = image_width_reg;
        cfg.image_height = image_height_reg;
        cfg.pixel_scale  = pixel_scale_reg;
        cfg.map_count    = map_count_reg;
    end

    // Front: accepts and classifies requests into a short queue.
    ifscg_front #(
        .MAX_MAPS (MAX_MAPS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop)
    );

    // Back: table updates, map selection, transform and pixel mapping.
    ifscg_back #(
        .MAX_MAPS    (MAX_MAPS),
        .RANDOM_BITS (RANDOM_BITS)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .q_pop    (q_pop),
        .cfg      (cfg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .pixel_x  (pixel_x),
        .pixel_y  (pixel_y),
        .hit      (m_tuser)
    );

    assign m_tdata = {pixel_y, pixel_x};

endmodule

/* rtl/ifscg_checker.sv */
// Port-level checks of the plotter and their binding to the top level.
module ifscg_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tuser,
    input logic        pready
);

    // A stalled result keeps its contents.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // A miss reports pixel zero.
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == 24'd0)
        else $error("miss with nonzero pixel");

    // Reset empties the output register and the request queue.
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("reset did not clear the data path");

    a_pready: assert property (@(posedge aclk) pready)
        else $error("configuration port not ready");

endmodule

bind ifs_chaos_game_plotter_unit ifscg_checker u_ifscg_checker (.*);
